FILE: rtl/pgwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pgwc_pkg;

    localparam int NUM_AREAS    = 2;
    localparam int AREAS_USED   = (NUM_AREAS < 2) ? NUM_AREAS : 2;
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 20;
    localparam int TAB_W        = $clog2(TAB_LEN);
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam int ARENA_X   = 30000;
    localparam int ARENA_Y   = 20000;
    localparam int GIMBAL_K  = 100000;

    localparam int CW    = 36;  // CORDIC datapath
    localparam int MA_W  = 35;  // multiplier operand a
    localparam int MB_W  = 18;  // multiplier operand b
    localparam int MP_W  = MA_W + MB_W;
    localparam int ANG_W = 16;
    localparam int TOL_W = 15;

    localparam logic [ANG_W-1:0] ANG_HALF = 16'h8000;

    localparam logic [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1, 16'd0,
        16'd0, 16'd0, 16'd0, 16'd0
    };

    localparam int CFG_W  = 3;
    localparam int CFG_DW = 64;

    localparam logic [CFG_W-1:0] CFG_XY_NOM   = 3'd0;
    localparam logic [CFG_W-1:0] CFG_YAW_NOM  = 3'd1;
    localparam logic [CFG_W-1:0] CFG_XY_ACC   = 3'd2;
    localparam logic [CFG_W-1:0] CFG_YAW_ACC  = 3'd3;
    localparam logic [CFG_W-1:0] CFG_STATEFUL = 3'd4;
    localparam logic [CFG_W-1:0] CFG_MARGIN   = 3'd5;
    localparam logic [CFG_W-1:0] CFG_BOX0     = 3'd6;
    localparam logic [CFG_W-1:0] CFG_BOX1     = 3'd7;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] query_x;
        logic signed [15:0] query_y;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic [63:0]        query_quat;
        logic [63:0]        goal_quat;
    } t_in;

    typedef struct packed {
        logic reached;
        logic accurate_mode;
        logic position_passed;
    } t_out;

    typedef struct packed {
        logic               start;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } t_cordic_req;

    typedef struct packed {
        logic             busy;
        logic [ANG_W-1:0] angle;
    } t_cordic_rsp;

endpackage

`default_nettype wire

FILE: rtl/pgwc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module pgwc_mul (
    input  logic                              i_clk,
    input  logic signed [pgwc_pkg::MA_W-1:0]  i_a,
    input  logic signed [pgwc_pkg::MB_W-1:0]  i_b,
    output logic signed [pgwc_pkg::MP_W-1:0]  o_p
);
    import pgwc_pkg::*;

    logic signed [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: rtl/pgwc_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module pgwc_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pgwc_pkg::t_cordic_req i_req,
    output pgwc_pkg::t_cordic_rsp o_rsp
);
    import pgwc_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    logic                 r_busy;
    logic [STEP_W-1:0]    r_step;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic [ANG_W-1:0]     r_ang;
    logic                 r_zero;
    logic signed [CW-1:0] sh_x;
    logic signed [CW-1:0] sh_y;
    logic [ANG_W-1:0]     tab_val;

    assign sh_x    = r_x >>> r_step;
    assign sh_y    = r_y >>> r_step;
    assign tab_val = ATAN_TAB[TAB_W'(r_step)];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_step == STEP_LAST) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_zero <= (i_req.x == '0) && (i_req.y == '0);
            if (i_req.x < 0) begin
                r_x   <= -i_req.x;
                r_y   <= -i_req.y;
                r_ang <= ANG_HALF;
            end else begin
                r_x   <= i_req.x;
                r_y   <= i_req.y;
                r_ang <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x   <= r_x + sh_y;
                r_y   <= r_y - sh_x;
                r_ang <= r_ang + tab_val;
            end else begin
                r_x   <= r_x - sh_y;
                r_y   <= r_y + sh_x;
                r_ang <= r_ang - tab_val;
            end
        end
    end

    assign o_rsp.busy  = r_busy;
    assign o_rsp.angle = r_zero ? '0 : r_ang;

endmodule

`default_nettype wire

FILE: rtl/pose_goal_window_checker.sv
// Pose goal-window checker. Takes one beat at a time: in_ready drops while an item is
// worked and rises again once its result sits in the output register, which may wait
// there for out_ready while the next beat is taken. A rearm item goes straight to the
// final state. A stalled output register holds an item in that final state until the
// register frees. A check item skips the position test once it is latched, and is paced
// by the shared 35x18 multiplier, which forms each quaternion's products in turn, and by
// the single CORDIC unit, which runs the query yaw behind the goal products and then the
// goal yaw on its own.
`timescale 1ns / 1ps
`default_nettype none

module pose_goal_window_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pgwc_pkg::CFG_W-1:0]    i_cfg_idx,
    input  logic [pgwc_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pgwc_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pgwc_pkg::t_out                o_out_data
);
    import pgwc_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_CLS   = 4'd1;
    localparam logic [ST_W-1:0] ST_POS0  = 4'd2;
    localparam logic [ST_W-1:0] ST_POS1  = 4'd3;
    localparam logic [ST_W-1:0] ST_POS2  = 4'd4;
    localparam logic [ST_W-1:0] ST_POS3  = 4'd5;
    localparam logic [ST_W-1:0] ST_PREP  = 4'd6;
    localparam logic [ST_W-1:0] ST_WAITQ = 4'd7;
    localparam logic [ST_W-1:0] ST_WAITG = 4'd8;
    localparam logic [ST_W-1:0] ST_DIFF  = 4'd9;
    localparam logic [ST_W-1:0] ST_FIN   = 4'd10;

    localparam int K_W = 4;
    localparam logic [K_W-1:0] K_XX  = 4'd0;
    localparam logic [K_W-1:0] K_YY  = 4'd1;
    localparam logic [K_W-1:0] K_ZZ  = 4'd2;
    localparam logic [K_W-1:0] K_WW  = 4'd3;
    localparam logic [K_W-1:0] K_XY  = 4'd4;
    localparam logic [K_W-1:0] K_WZ  = 4'd5;
    localparam logic [K_W-1:0] K_WY  = 4'd6;
    localparam logic [K_W-1:0] K_XZ  = 4'd7;
    localparam logic [K_W-1:0] K_S   = 4'd8;
    localparam logic [K_W-1:0] K_T1  = 4'd9;
    localparam logic [K_W-1:0] K_T2  = 4'd10;
    localparam logic [K_W-1:0] K_END = 4'd11;

    localparam logic [ANG_W:0] YAW_FULL = 17'h10000;

    // configuration
    logic [TOL_W-1:0]  r_xy_nom;
    logic [TOL_W-1:0]  r_yaw_nom;
    logic [TOL_W-1:0]  r_xy_acc;
    logic [TOL_W-1:0]  r_yaw_acc;
    logic              r_stateful;
    logic [TOL_W-1:0]  r_margin;
    logic [CFG_DW-1:0] r_box [2];

    // control
    logic [ST_W-1:0] r_state;
    logic [ST_W-1:0] n_state;
    logic [K_W-1:0]  r_k;
    logic            r_sel_goal;
    logic            r_latch;
    logic            r_out_valid;

    // datapath
    t_in                  r_in;
    t_out                 r_out;
    logic                 r_acc;
    logic                 r_reached;
    logic [33:0]          r_dist;
    logic signed [MA_W-1:0] r_n;
    logic signed [32:0]   r_x;
    logic signed [32:0]   r_y;
    logic signed [32:0]   r_s;
    logic                 r_gneg;
    logic                 r_gpos;
    logic                 r_q_neg;
    logic                 r_q_pos;
    logic [ANG_W-1:0]     r_yaw_q;
    logic [ANG_W-1:0]     r_yaw_g;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] prod;
    logic signed [31:0]     p32;

    t_cordic_req cordic_req;
    t_cordic_rsp cordic_rsp;

    logic               in_acc;
    logic               out_free;
    logic [63:0]        cur_quat;
    logic signed [15:0] c_x;
    logic signed [15:0] c_y;
    logic signed [15:0] c_z;
    logic signed [15:0] c_w;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [TOL_W-1:0]   xy_tol;
    logic [TOL_W-1:0]   yaw_tol;
    logic signed [MA_W-1:0] s2;
    logic signed [MA_W-1:0] t1;
    logic signed [MA_W-1:0] t2;
    logic               gpos_now;
    logic               op_neg;
    logic               op_pos;
    logic               near_wall;
    logic               in_area;
    logic signed [17:0] gx;
    logic signed [17:0] gy;
    logic signed [17:0] m_ext;
    logic signed [17:0] lim_x;
    logic signed [17:0] lim_y;
    logic [ANG_W-1:0]   yaw_d;
    logic [ANG_W:0]     yaw_mag;

    function automatic logic [ANG_W-1:0] fix_yaw(input logic neg, input logic pos,
                                                 input logic [ANG_W-1:0] ang);
        logic [ANG_W-1:0] dbl;
        dbl = {ang[ANG_W-2:0], 1'b0};
        if (neg) begin
            fix_yaw = '0 - dbl;
        end else if (pos) begin
            fix_yaw = dbl;
        end else begin
            fix_yaw = ang;
        end
    endfunction

    pgwc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    pgwc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cordic_req),
        .o_rsp   (cordic_rsp)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign cur_quat = r_sel_goal ? r_in.goal_quat : r_in.query_quat;
    assign c_x      = $signed(cur_quat[15:0]);
    assign c_y      = $signed(cur_quat[31:16]);
    assign c_z      = $signed(cur_quat[47:32]);
    assign c_w      = $signed(cur_quat[63:48]);
    assign p32      = $signed(prod[31:0]);

    assign dx = 17'($signed(r_in.query_x)) - 17'($signed(r_in.goal_x));
    assign dy = 17'($signed(r_in.query_y)) - 17'($signed(r_in.goal_y));

    assign xy_tol  = r_acc ? r_xy_acc : r_xy_nom;
    assign yaw_tol = r_acc ? r_yaw_acc : r_yaw_nom;

    assign s2 = {r_s[32], r_s, 1'b0};
    assign t1 = r_n + s2;
    assign t2 = r_n - s2;
    assign gpos_now = (r_n != '0) && (prod <= MP_W'(r_n));

    // accurate-mode classification
    assign gx    = 18'($signed(r_in.goal_x));
    assign gy    = 18'($signed(r_in.goal_y));
    assign m_ext = $signed({3'b000, r_margin});
    assign lim_x = 18'(ARENA_X) - m_ext;
    assign lim_y = 18'(ARENA_Y) - m_ext;
    assign near_wall = (gx < m_ext) || (gx > lim_x) || (gy < m_ext) || (gy > lim_y);

    always_comb begin
        in_area = 1'b0;
        for (int i = 0; i < AREAS_USED; i++) begin
            if (($signed(r_in.goal_x) > $signed(r_box[i][15:0])) &&
                ($signed(r_in.goal_x) < $signed(r_box[i][47:32])) &&
                ($signed(r_in.goal_y) > $signed(r_box[i][31:16])) &&
                ($signed(r_in.goal_y) < $signed(r_box[i][63:48]))) begin
                in_area = 1'b1;
            end
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_POS0: begin
                mul_a = MA_W'(dx);
                mul_b = MB_W'(dx);
            end
            ST_POS1: begin
                mul_a = MA_W'(dy);
                mul_b = MB_W'(dy);
            end
            ST_POS2: begin
                mul_a = $signed({{(MA_W-TOL_W){1'b0}}, xy_tol});
                mul_b = $signed({{(MB_W-TOL_W){1'b0}}, xy_tol});
            end
            ST_PREP: begin
                case (r_k)
                    K_XX: begin
                        mul_a = MA_W'(c_x);
                        mul_b = MB_W'(c_x);
                    end
                    K_YY: begin
                        mul_a = MA_W'(c_y);
                        mul_b = MB_W'(c_y);
                    end
                    K_ZZ: begin
                        mul_a = MA_W'(c_z);
                        mul_b = MB_W'(c_z);
                    end
                    K_WW: begin
                        mul_a = MA_W'(c_w);
                        mul_b = MB_W'(c_w);
                    end
                    K_XY: begin
                        mul_a = MA_W'(c_x);
                        mul_b = MB_W'(c_y);
                    end
                    K_WZ: begin
                        mul_a = MA_W'(c_w);
                        mul_b = MB_W'(c_z);
                    end
                    K_WY: begin
                        mul_a = MA_W'(c_w);
                        mul_b = MB_W'(c_y);
                    end
                    K_XZ: begin
                        mul_a = MA_W'(c_x);
                        mul_b = MB_W'(c_z);
                    end
                    K_T1: begin
                        mul_a = t1;
                        mul_b = MB_W'(GIMBAL_K);
                    end
                    K_T2: begin
                        mul_a = t2;
                        mul_b = MB_W'(GIMBAL_K);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // CORDIC launch: query at the end of its products, goal once the query pass is done
    always_comb begin
        if (r_state == ST_PREP) begin
            op_neg = r_gneg;
            op_pos = gpos_now && !r_gneg;
        end else begin
            op_neg = r_gneg;
            op_pos = r_gpos;
        end
        cordic_req.start = ((r_state == ST_PREP) && (r_k == K_END) && !r_sel_goal) ||
                           ((r_state == ST_WAITQ) && !cordic_rsp.busy);
        if (op_neg || op_pos) begin
            cordic_req.y = CW'(c_y) <<< 14;
            cordic_req.x = CW'(c_x) <<< 14;
        end else begin
            cordic_req.y = CW'(r_y) <<< 1;
            cordic_req.x = CW'(r_x);
        end
    end

    assign yaw_d   = r_yaw_g - r_yaw_q;
    assign yaw_mag = yaw_d[ANG_W-1] ? (YAW_FULL - {1'b0, yaw_d}) : {1'b0, yaw_d};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = i_in_data.opcode ? ST_FIN : ST_CLS;
                end
            end
            ST_CLS:  n_state = r_latch ? ST_PREP : ST_POS0;
            ST_POS0: n_state = ST_POS1;
            ST_POS1: n_state = ST_POS2;
            ST_POS2: n_state = ST_POS3;
            ST_POS3: n_state = (r_dist > prod[33:0]) ? ST_FIN : ST_PREP;
            ST_PREP: begin
                if ((r_k == K_END) && r_sel_goal) begin
                    n_state = ST_WAITQ;
                end
            end
            ST_WAITQ: begin
                if (!cordic_rsp.busy) begin
                    n_state = ST_WAITG;
                end
            end
            ST_WAITG: begin
                if (!cordic_rsp.busy) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_sel_goal  <= 1'b0;
            r_latch     <= 1'b0;
            r_out_valid <= 1'b0;
            r_xy_nom    <= 15'd300;
            r_yaw_nom   <= 15'd522;
            r_xy_acc    <= 15'd100;
            r_yaw_acc   <= 15'd104;
            r_stateful  <= 1'b1;
            r_margin    <= 15'd1500;
            r_box[0]    <= '0;
            r_box[1]    <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_XY_NOM:   r_xy_nom   <= i_cfg_data[TOL_W-1:0];
                    CFG_YAW_NOM:  r_yaw_nom  <= i_cfg_data[TOL_W-1:0];
                    CFG_XY_ACC:   r_xy_acc   <= i_cfg_data[TOL_W-1:0];
                    CFG_YAW_ACC:  r_yaw_acc  <= i_cfg_data[TOL_W-1:0];
                    CFG_STATEFUL: r_stateful <= i_cfg_data[0];
                    CFG_MARGIN:   r_margin   <= i_cfg_data[TOL_W-1:0];
                    CFG_BOX0:     r_box[0]   <= i_cfg_data;
                    CFG_BOX1:     r_box[1]   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (in_acc && i_in_data.opcode) begin
                r_latch <= 1'b0;
            end else if ((r_state == ST_POS3) && !(r_dist > prod[33:0]) && r_stateful) begin
                r_latch <= 1'b1;
            end

            if ((r_state == ST_CLS) || (r_state == ST_POS3)) begin
                r_k        <= '0;
                r_sel_goal <= 1'b0;
            end else if (r_state == ST_PREP) begin
                if (r_k == K_END) begin
                    r_k        <= '0;
                    r_sel_goal <= 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end

            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
            if (i_in_data.opcode) begin
                r_acc     <= 1'b0;
                r_reached <= 1'b0;
            end
        end

        if (r_state == ST_CLS) begin
            r_acc     <= near_wall || in_area;
            r_reached <= 1'b0;
        end

        if (r_state == ST_POS1) begin
            r_dist <= prod[33:0];
        end else if (r_state == ST_POS2) begin
            r_dist <= r_dist + prod[33:0];
        end

        if (r_state == ST_PREP) begin
            case (r_k)
                K_YY: begin
                    r_n <= MA_W'(p32);
                    r_x <= 33'(p32);
                end
                K_ZZ, K_WW: begin
                    r_n <= r_n + MA_W'(p32);
                    r_x <= r_x - 33'(p32);
                end
                K_XY: begin
                    r_n <= r_n + MA_W'(p32);
                    r_x <= r_x + 33'(p32);
                end
                K_WZ: r_y <= 33'(p32);
                K_WY: r_y <= r_y + 33'(p32);
                K_XZ: r_s <= 33'(p32);
                K_S:  r_s <= r_s - 33'(p32);
                K_T2: r_gneg <= (r_n != '0) && (prod <= MP_W'(r_n));
                K_END: begin
                    r_gpos <= gpos_now && !r_gneg;
                    if (!r_sel_goal) begin
                        r_q_neg <= r_gneg;
                        r_q_pos <= gpos_now && !r_gneg;
                    end
                end
                default: begin
                end
            endcase
        end

        if ((r_state == ST_WAITQ) && !cordic_rsp.busy) begin
            r_yaw_q <= fix_yaw(r_q_neg, r_q_pos, cordic_rsp.angle);
        end
        if ((r_state == ST_WAITG) && !cordic_rsp.busy) begin
            r_yaw_g <= fix_yaw(r_gneg, r_gpos, cordic_rsp.angle);
        end

        if (r_state == ST_DIFF) begin
            r_reached <= yaw_mag < {2'b00, yaw_tol};
        end

        if ((r_state == ST_FIN) && out_free) begin
            r_out.reached         <= r_reached;
            r_out.accurate_mode   <= r_acc;
            r_out.position_passed <= r_latch;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pgwc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pgwc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input pgwc_pkg::t_in               i_in_data,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input pgwc_pkg::t_out              o_out_data
);
    import pgwc_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat dropped or changed under stall");

    // one item at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    // rearm with a free output slot gives an all-zero result
    a_rearm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.opcode && !o_out_valid) |=> ##1
        (o_out_valid && !o_out_data.reached && !o_out_data.accurate_mode &&
         !o_out_data.position_passed))
        else $error("rearm result wrong or late");

    // a result only appears at the end of an item's work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(o_in_ready) == 1'b0))
        else $error("result appeared without an item in flight");

endmodule

bind pose_goal_window_checker pgwc_checker u_pgwc_checker (.*);

`default_nettype wire
